>>> design/sha1sh_pkg.sv
// Package for the SHA-1 stream hasher: sequencer state type, memory write
// record, SHA-1 constants and the round functions. No dependencies.
package sha1sh_pkg;

   localparam int unsigned ROUNDS    = 80;
   localparam int unsigned WORDS     = 16;
   localparam int unsigned DIGEST_N  = 5;

   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   localparam logic [7:0]  PAD_MARK  = 8'h80;
   localparam logic [3:0]  LEN_WORD_HI = 4'd14;
   localparam logic [3:0]  LEN_WORD_LO = 4'd15;
   localparam logic [3:0]  LAST_WORD_ADDR = 4'd15;
   localparam logic [5:0]  LAST_BYTE = 6'd63;
   localparam logic [6:0]  LAST_ROUND = 7'd79;
   localparam logic [6:0]  FIRST_EXPANDED = 7'd16;
   localparam logic [2:0]  LAST_INDEX = 3'd4;

   localparam logic [31:0] K_0 = 32'h5a827999;
   localparam logic [31:0] K_1 = 32'h6ed9eba1;
   localparam logic [31:0] K_2 = 32'h8f1bbcdc;
   localparam logic [31:0] K_3 = 32'hca62c1d6;

   localparam logic [4:0][31:0] H_INIT = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        en;
      logic [3:0]  addr;
      logic [3:0]  be;
      logic [31:0] data;
   } mem_wr_type;

   function automatic logic [31:0] rotl1(input logic [31:0] x);
      return {x[30:0], x[31]};
   endfunction

   function automatic logic [31:0] rotl5(input logic [31:0] x);
      return {x[26:0], x[31:27]};
   endfunction

   function automatic logic [31:0] rotl30(input logic [31:0] x);
      return {x[1:0], x[31:2]};
   endfunction

   function automatic logic [31:0] round_k(input logic [6:0] r);
      logic [31:0] k;
      if (r < 7'd20) begin
         k = K_0;
      end else if (r < 7'd40) begin
         k = K_1;
      end else if (r < 7'd60) begin
         k = K_2;
      end else begin
         k = K_3;
      end
      return k;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (r < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (r < 7'd40) begin
         f = b ^ c ^ d;
      end else if (r < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

>>> design/sha1sh_chan_if.sv
// Channel interfaces of the SHA-1 stream hasher: the request channel that
// carries message bytes and finish commands, and the digest response channel.
interface sha1sh_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface sha1sh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

>>> design/sha1_stream_hasher_unit.sv
// SHA-1 stream hasher top level. An append writes one byte; one that fills a block starts a
// compression (load, 80 rounds each in a read and an update phase, fold). A finish pads the
// rest of the block and compresses it; a tail of 56 or more bytes adds a second pad block
// and compression. Five digest transactions follow, one per cycle while accepted.
// The rounds share one 16 x 32-bit memory with two read ports; each round needs four
// schedule reads. Reset clears control and count and loads the initial chaining values.
module sha1_stream_hasher_unit (
   input  logic           clock,
   input  logic           reset,
   sha1sh_req_if.sink     req_chan,
   sha1sh_rsp_if.source   rsp_chan
);
   import sha1sh_pkg::*;

   logic [3:0][7:0] sched_mem [WORDS];

   state_type        state_ff, state_in;
   logic [6:0]       round_ff, round_in;
   logic             ph_ff, ph_in;
   logic [3:0]       word_ff, word_in;
   logic [2:0]       idx_ff, idx_in;
   logic             finish_ff, finish_in;
   logic             second_ff, second_in;
   logic [63:0]      count_ff, count_in;
   logic [4:0][31:0] chain_ff, chain_in;
   logic [4:0][31:0] work_ff, work_in;
   logic [31:0]      wa_ff, wa_in;
   logic [31:0]      p_ff, p_in;
   logic [31:0]      ek_ff, ek_in;
   logic [31:0]      qa_ff, qb_ff;

   logic [3:0]  rd_a, rd_b;
   mem_wr_type  wr;
   logic [5:0]  fill;
   logic        spill;
   logic [63:0] bit_len;
   logic [31:0] w_cur;
   logic [31:0] t_sum;
   logic        req_take;

   assign fill     = count_ff[5:0];
   assign spill    = (count_ff[5:3] == 3'd7);
   assign bit_len  = {count_ff[60:0], 3'b000};
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = (state_ff == ST_EMIT);
   assign rsp_chan.digest_word = chain_ff[idx_ff];
   assign rsp_chan.word_index  = idx_ff;
   assign rsp_chan.last_word   = (idx_ff == LAST_INDEX);

   assign w_cur = (round_ff < FIRST_EXPANDED) ? wa_ff : rotl1(p_ff ^ qa_ff ^ qb_ff);
   assign t_sum = rotl5(work_ff[0]) + round_f(round_ff, work_ff[1], work_ff[2], work_ff[3])
                  + ek_ff + w_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         round_ff  <= '0;
         ph_ff     <= 1'b0;
         word_ff   <= '0;
         idx_ff    <= '0;
         finish_ff <= 1'b0;
         second_ff <= 1'b0;
         count_ff  <= '0;
         chain_ff  <= H_INIT;
         work_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         round_ff  <= round_in;
         ph_ff     <= ph_in;
         word_ff   <= word_in;
         idx_ff    <= idx_in;
         finish_ff <= finish_in;
         second_ff <= second_in;
         count_ff  <= count_in;
         chain_ff  <= chain_in;
         work_ff   <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff <= wa_in;
      p_ff  <= p_in;
      ek_ff <= ek_in;
   end

   always_ff @(posedge clock) begin
      qa_ff <= sched_mem[rd_a];
      qb_ff <= sched_mem[rd_b];
      if (wr.en) begin
         for (int l = 0; l < 4; l++) begin
            if (wr.be[l]) begin
               sched_mem[wr.addr][l] <= wr.data[8*l +: 8];
            end
         end
      end
   end

   always_comb begin
      logic [5:0] pos;
      state_in  = state_ff;
      round_in  = round_ff;
      ph_in     = ph_ff;
      word_in   = word_ff;
      idx_in    = idx_ff;
      finish_in = finish_ff;
      second_in = second_ff;
      count_in  = count_ff;
      chain_in  = chain_ff;
      work_in   = work_ff;
      wa_in     = wa_ff;
      p_in      = p_ff;
      ek_in     = ek_ff;
      rd_a      = round_ff[3:0] + 4'd1;
      rd_b      = round_ff[3:0] + 4'd3;
      wr        = '0;
      pos       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_chan.kind == KIND_APPEND) begin
                  wr.en    = 1'b1;
                  wr.addr  = fill[5:2];
                  wr.be    = 4'b0001 << (~fill[1:0]);
                  wr.data  = {4{req_chan.data_byte}};
                  count_in = count_ff + 64'd1;
                  if (fill == LAST_BYTE) begin
                     finish_in = 1'b0;
                     state_in  = ST_LOAD;
                  end
               end else begin
                  finish_in = 1'b1;
                  second_in = 1'b0;
                  word_in   = fill[5:2];
                  state_in  = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            wr.en   = 1'b1;
            wr.addr = word_ff;
            for (int l = 0; l < 4; l++) begin
               pos = {word_ff, 2'(3 - l)};
               if (second_ff) begin
                  wr.be[l] = 1'b1;
               end else if (pos < fill) begin
                  wr.be[l] = 1'b0;
               end else if (pos == fill) begin
                  wr.be[l]         = 1'b1;
                  wr.data[8*l +: 8] = PAD_MARK;
               end else begin
                  wr.be[l] = 1'b1;
               end
            end
            if (second_ff || !spill) begin
               if (word_ff == LEN_WORD_HI) begin
                  wr.be   = 4'hf;
                  wr.data = bit_len[63:32];
               end else if (word_ff == LEN_WORD_LO) begin
                  wr.be   = 4'hf;
                  wr.data = bit_len[31:0];
               end
            end
            word_in = word_ff + 4'd1;
            if (word_ff == LAST_WORD_ADDR) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            work_in  = chain_ff;
            round_in = '0;
            ph_in    = 1'b0;
            rd_a     = 4'd0;
            rd_b     = 4'd2;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (!ph_ff) begin
               wa_in = qa_ff;
               p_in  = qa_ff ^ qb_ff;
               ek_in = work_ff[4] + round_k(round_ff);
               rd_a  = round_ff[3:0] + 4'd8;
               rd_b  = round_ff[3:0] + 4'd13;
               ph_in = 1'b1;
            end else begin
               work_in[4] = work_ff[3];
               work_in[3] = work_ff[2];
               work_in[2] = rotl30(work_ff[1]);
               work_in[1] = work_ff[0];
               work_in[0] = t_sum;
               if (round_ff >= FIRST_EXPANDED) begin
                  wr.en   = 1'b1;
                  wr.addr = round_ff[3:0];
                  wr.be   = 4'hf;
                  wr.data = w_cur;
               end
               ph_in    = 1'b0;
               round_in = round_ff + 7'd1;
               if (round_ff == LAST_ROUND) begin
                  state_in = ST_FOLD;
               end
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < DIGEST_N; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            if (!finish_ff) begin
               state_in = ST_IDLE;
            end else if (spill && !second_ff) begin
               second_in = 1'b1;
               word_in   = '0;
               state_in  = ST_PAD;
            end else begin
               idx_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_chan.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LAST_INDEX) begin
                  chain_in  = H_INIT;
                  count_in  = '0;
                  finish_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request accepted while a digest is being presented");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_word) |=>
         (req_chan.ready && count_ff == 64'd0))
      else $error("hasher did not restart after the last digest word");

   a_word_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_word) |=>
         (rsp_chan.valid && rsp_chan.word_index == $past(rsp_chan.word_index) + 3'd1))
      else $error("digest words out of order");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (round_ff <= LAST_ROUND))
      else $error("round counter out of range");

endmodule

>>> dv/sha1_stream_hasher_unit_tb.sv
// Testbench for sha1_stream_hasher_unit: feeds byte streams and finish commands,
// predicts every SHA-1 digest word and checks it against the response channel.
// Depends on sha1sh_pkg and the channel interfaces in sha1sh_chan_if.sv.
module sha1_stream_hasher_unit_tb;
   import sha1sh_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned SETTLE_CYCLES = 400;
   localparam int unsigned REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   logic clock;
   logic reset;

   sha1sh_req_if req_chan ();
   sha1sh_rsp_if rsp_chan ();

   sha1_stream_hasher_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [31:0]     chain_h [DIGEST_N];
   logic [7:0]      block_bytes [64];
   logic [63:0]     byte_count;
   digest_beat_type pending_digest_words [$];
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count = 0;
   bit              steady_flow = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned idle_cycles();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 55) begin
         return 0;
      end else if (roll < 88) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic void start_new_message();
      for (int i = 0; i < DIGEST_N; i++) begin
         chain_h[i] = H_INIT[i];
      end
      byte_count = 64'd0;
   endfunction

   function automatic void compress_block_bytes();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      for (int i = 0; i < 16; i++) begin
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      end
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int r = 0; r < ROUNDS; r++) begin
         if (r >= 16) begin
            x = w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16];
            w[r % 16] = {x[30:0], x[31]};
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_2;
         end else begin
            f = b ^ c ^ d;
            k = K_3;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[r % 16];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endfunction

   function automatic void absorb_item(input logic item_kind, input logic [7:0] item_byte);
      int unsigned     fill;
      logic [63:0]     bit_length;
      digest_beat_type beat;
      fill = byte_count[5:0];
      if (item_kind == KIND_APPEND) begin
         block_bytes[fill] = item_byte;
         byte_count = byte_count + 64'd1;
         if (fill == 63) begin
            compress_block_bytes();
         end
      end else begin
         bit_length = byte_count << 3;
         block_bytes[fill] = PAD_MARK;
         for (int i = fill + 1; i < 64; i++) begin
            block_bytes[i] = 8'h00;
         end
         if (fill >= 56) begin
            compress_block_bytes();
            for (int i = 0; i < 56; i++) begin
               block_bytes[i] = 8'h00;
            end
         end
         for (int i = 0; i < 8; i++) begin
            block_bytes[56 + i] = bit_length[63 - 8*i -: 8];
         end
         compress_block_bytes();
         for (int i = 0; i < DIGEST_N; i++) begin
            beat.digest_word = chain_h[i];
            beat.word_index  = 3'(i);
            beat.last_word   = (3'(i) == LAST_INDEX);
            pending_digest_words.push_back(beat);
         end
         start_new_message();
      end
   endfunction

   task automatic send_item(input logic item_kind, input logic [7:0] item_byte);
      int unsigned gap;
      gap = idle_cycles();
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.kind      = item_kind;
      req_chan.data_byte = item_byte;
      do @(posedge clock); while (!req_chan.ready);
      absorb_item(item_kind, item_byte);
   endtask

   task automatic hash_random_message(input int unsigned length);
      for (int unsigned i = 0; i < length; i++) begin
         send_item(KIND_APPEND, 8'($urandom_range(0, 255)));
      end
      send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_empty_message();
      send_item(KIND_FINISH, 8'h00);
      send_item(KIND_FINISH, 8'hff);
   endtask

   task automatic test_extreme_bytes();
      send_item(KIND_APPEND, 8'h00);
      send_item(KIND_FINISH, 8'h00);
      send_item(KIND_APPEND, 8'hff);
      send_item(KIND_FINISH, 8'hff);
      send_item(KIND_APPEND, 8'h61);
      send_item(KIND_APPEND, 8'h62);
      send_item(KIND_APPEND, 8'h63);
      send_item(KIND_FINISH, 8'h00);
   endtask

   // Tails of 56 bytes or more force the length field into a second block.
   task automatic test_padding_boundaries();
      hash_random_message(55);
      hash_random_message(56);
      hash_random_message(63);
      hash_random_message(64);
   endtask

   task automatic test_random_messages();
      int unsigned sent;
      int unsigned length;
      sent = 0;
      while (sent < 80) begin
         steady_flow = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 99) < 80) begin
            length = $urandom_range(0, 12);
         end else begin
            unique case ($urandom_range(0, 3))
               0: begin
                  length = 54;
               end
               1: begin
                  length = 57;
               end
               2: begin
                  length = 62;
               end
               default: begin
                  length = 65;
               end
            endcase
         end
         hash_random_message(length);
         sent += length + 1;
      end
      steady_flow = 1'b0;
   endtask

   initial begin : response_stalls
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = idle_cycles();
         if (stall == 0) begin
            rsp_chan.ready = 1'b1;
         end else begin
            rsp_chan.ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_digest
      digest_beat_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_digest_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected digest transaction: word %h index %0d last %b",
                        rsp_chan.digest_word, rsp_chan.word_index, rsp_chan.last_word);
            end
         end else begin
            want = pending_digest_words.pop_front();
            if (rsp_chan.digest_word !== want.digest_word ||
                rsp_chan.word_index !== want.word_index ||
                rsp_chan.last_word !== want.last_word) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                           want.digest_word, want.word_index, want.last_word,
                           rsp_chan.digest_word, rsp_chan.word_index, rsp_chan.last_word);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.kind      = KIND_APPEND;
      req_chan.data_byte = 8'h00;
      start_new_message();
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_empty_message();
      test_extreme_bytes();
      test_padding_boundaries();
      test_random_messages();

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_digest_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
design/sha1sh_pkg.sv
design/sha1sh_chan_if.sv
design/sha1_stream_hasher_unit.sv
dv/sha1_stream_hasher_unit_tb.sv
